FILE: rtl/core/tfcc_pkg.sv
// shared types and constants for the telemetry frame crc checker
package tfcc_pkg;

	// frame layout: payload bytes, then checksum low and high byte
	localparam int unsigned PayloadBytes = 20;
	localparam int unsigned PosWidth = 5;
	localparam logic [PosWidth-1:0] PosCsumLo = PosWidth'(PayloadBytes);
	localparam logic [PosWidth-1:0] PosCsumHi = PosWidth'(PayloadBytes + 1);

	// crc-16, msb first, zero init, no final xor
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcTop = 16'h8000;

	typedef enum logic {
		MODE_BYTE    = 1'b0,
		MODE_TIMEOUT = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_SHORT    = 2'd2
	} status_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] speed_left;
		logic signed [15:0] speed_right;
		logic        [15:0] battery_volts;
		logic signed [15:0] current_left;
		logic signed [15:0] current_right;
		logic signed [31:0] odometer_left;
		logic signed [31:0] odometer_right;
	} out_item_t;

endpackage

FILE: rtl/core/tfcc_crc16.sv
// byte-wide crc-16 update, eight bit steps unrolled
module tfcc_crc16 (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);
	import tfcc_pkg::*;

	// shift the byte in msb first
	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CrcTop) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

FILE: rtl/core/tfcc_frame.sv
// frame tracking: byte position, running crc, payload store and result forming
module tfcc_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  tfcc_pkg::in_item_t   item,
	output logic                 result_valid,
	output tfcc_pkg::out_item_t  result
);
	import tfcc_pkg::*;

	logic [PosWidth-1:0] pos_q;
	logic [15:0]         crc_q;
	logic [7:0]          csum_lo_q;
	logic [7:0]          bytes_q [PayloadBytes];
	logic [15:0]         crc_next;
	logic [15:0]         received;

	tfcc_crc16 u_crc (
		.crc      (crc_q),
		.data     (item.rx_byte),
		.crc_next (crc_next)
	);

	// an item gives a result on a timeout or on the checksum high byte
	assign result_valid = (item.mode == MODE_TIMEOUT) || (pos_q >= PosCsumHi);
	assign received = {item.rx_byte, csum_lo_q};

	// form the result: short read on a timeout, else crc status and little-endian payload fields
	always_comb begin
		if (item.mode == MODE_TIMEOUT) begin
			result = '0;
			result.status = ST_SHORT;
		end else begin
			result.status = (received == crc_q) ? ST_VALID : ST_MISMATCH;
			result.speed_left = {bytes_q[3], bytes_q[2]};
			result.speed_right = {bytes_q[5], bytes_q[4]};
			result.battery_volts = {bytes_q[7], bytes_q[6]};
			result.current_left = {bytes_q[9], bytes_q[8]};
			result.current_right = {bytes_q[11], bytes_q[10]};
			result.odometer_left = {bytes_q[15], bytes_q[14], bytes_q[13], bytes_q[12]};
			result.odometer_right = {bytes_q[19], bytes_q[18], bytes_q[17], bytes_q[16]};
		end
	end

	// position and crc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= '0;
			csum_lo_q <= '0;
		end else if (step) begin
			if (item.mode == MODE_TIMEOUT) begin
				pos_q <= '0;
				crc_q <= '0;
			end else if (pos_q < PosCsumLo) begin
				pos_q <= pos_q + PosWidth'(1);
				crc_q <= crc_next;
			end else if (pos_q == PosCsumLo) begin
				csum_lo_q <= item.rx_byte;
				pos_q <= PosCsumHi;
			end else begin
				pos_q <= '0;
				crc_q <= '0;
			end
		end
	end

	// payload store, each entry written before it is read
	always_ff @(posedge clk) begin
		if (step && item.mode == MODE_BYTE && pos_q < PosCsumLo) begin
			bytes_q[pos_q] <= item.rx_byte;
		end
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosCsumHi)
		else $error("byte position beyond checksum high byte");

	a_timeout_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == MODE_TIMEOUT |=> pos_q == '0 && crc_q == '0)
		else $error("timeout did not restart the frame");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.mode == MODE_BYTE && pos_q == PosCsumHi |=> pos_q == '0 && crc_q == '0)
		else $error("frame end did not restart the frame");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_SHORT |->
			result.odometer_left == '0 && result.speed_left == '0)
		else $error("short read result carries data");
`endif

endmodule

FILE: rtl/core/telemetry_frame_crc_checker.sv
// top level of the telemetry frame crc checker
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one item per byte: mode
//   byte with rx_byte, or mode timeout for a short read. Frames are 22 bytes:
//   20 payload bytes feeding a crc-16 (0x1021, zero init, msb first), then
//   the received checksum, low byte first.
//   out channel (out_valid/out_ready/out_data) gives one item per frame on
//   the last checksum byte, with status valid or crc mismatch and the
//   unpacked little-endian fields, and one item per timeout with status
//   short read and all other fields zero.
//   Throughput: one item per cycle while in_ready is high; the crc byte
//   update is one combinational step between the input register and the
//   frame state. A result goes through the input register, then the output
//   register, before it shows on out_valid.
//   Reset clears the byte position, crc and both valid flags; the payload
//   store is not cleared, every byte is written before it is read.
//   When the receiver stalls, the output register holds its item; items that
//   give no result keep flowing, and in_ready falls only when an item that
//   gives a result waits in the input register behind a full output register.
module telemetry_frame_crc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tfcc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tfcc_pkg::out_item_t  out_data
);
	import tfcc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      frame_step;
	logic      result_valid;
	out_item_t result;

	// the stage-one item moves on unless its result has nowhere to go
	assign frame_step = valid_s1 && (!result_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || frame_step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	tfcc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (frame_step),
		.item         (item_s1),
		.result_valid (result_valid),
		.result       (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_step && result_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_step && result_valid) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
